// ===== hw/rtl/uks_pkg.sv =====
// Package for the unsigned key sorter: beat types, cell control type and defaults.
// No dependencies.
`default_nettype none

package uks_pkg;

   localparam int KEY_WIDTH        = 64;
   localparam int MAX_KEYS_DEFAULT = 64;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key_in;
      logic                 batch_end;
   } req_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key_out;
      logic                 final_key;
      logic                 overflowed;
   } rsp_type;

   typedef struct packed {
      logic                 insert;
      logic                 shift;
      logic [KEY_WIDTH-1:0] key;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/uks_cell.sv =====
// One sorter cell: holds one key and a valid bit; inserts by shifting toward the tail,
// drains by shifting toward the head. Depends on uks_pkg.
`default_nettype none

module uks_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire uks_pkg::cell_ctl_type          ctl,
   input  wire logic                           up_valid,
   input  wire logic                           up_gt,
   input  wire logic [uks_pkg::KEY_WIDTH-1:0]  up_key,
   input  wire logic                           dn_valid,
   input  wire logic [uks_pkg::KEY_WIDTH-1:0]  dn_key,
   output logic                                valid_out,
   output logic                                gt_out,
   output logic [uks_pkg::KEY_WIDTH-1:0]       key_out
);
   import uks_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   // empty cells count as greater than any key; equal keys stay ahead
   assign gt_out    = !valid_ff || (key_ff > ctl.key);
   assign valid_out = valid_ff;
   assign key_out   = key_ff;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         key_in   = dn_key;
         valid_in = dn_valid;
      end else if (ctl.insert && gt_out) begin
         key_in   = up_gt ? up_key : ctl.key;
         valid_in = valid_ff | up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/unsigned_key_sorter.sv =====
// Unsigned key sorter: insertion chain of uks_cell, head of chain drives the result beat.
// Depends on uks_pkg and uks_cell.
// Key beats are taken one per cycle while req_stall is low.
// Results start the cycle after the batch_end beat, one per cycle at the chain head while
// rsp_stall is low; req_stall is high while the held keys drain.
// Reset empties the chain (valid bits) and clears the drain and overflow flags.
`default_nettype none

module unsigned_key_sorter #(
   parameter int MAX_KEYS = uks_pkg::MAX_KEYS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire uks_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output uks_pkg::rsp_type      rsp_data
);
   import uks_pkg::*;

   logic                 drain_ff;
   logic                 drain_in;
   logic                 lost_ff;
   logic                 lost_in;
   logic                 req_accept;
   logic                 rsp_accept;
   logic                 full;
   logic                 last_held;
   cell_ctl_type         ctl;

   logic [MAX_KEYS-1:0]  vld_w;
   logic [MAX_KEYS-1:0]  gt_w;
   logic [KEY_WIDTH-1:0] key_w [MAX_KEYS];
   logic [MAX_KEYS-1:0]  up_vld_w;
   logic [MAX_KEYS-1:0]  up_gt_w;
   logic [KEY_WIDTH-1:0] up_key_w [MAX_KEYS];
   logic [MAX_KEYS-1:0]  dn_vld_w;
   logic [KEY_WIDTH-1:0] dn_key_w [MAX_KEYS];

   assign req_stall  = drain_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = drain_ff;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign full       = vld_w[MAX_KEYS-1];
   assign last_held  = !vld_w[1];

   assign ctl.insert = req_accept && !full;
   assign ctl.shift  = rsp_accept;
   assign ctl.key    = req_data.key_in;

   assign rsp_data.key_out    = key_w[0];
   assign rsp_data.final_key  = last_held;
   assign rsp_data.overflowed = lost_ff;

   generate
      for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign up_vld_w[i] = 1'b1;
            assign up_gt_w[i]  = 1'b0;
            assign up_key_w[i] = '0;
         end else begin : g_body
            assign up_vld_w[i] = vld_w[i-1];
            assign up_gt_w[i]  = gt_w[i-1];
            assign up_key_w[i] = key_w[i-1];
         end
         if (i == MAX_KEYS - 1) begin : g_tail
            assign dn_vld_w[i] = 1'b0;
            assign dn_key_w[i] = '0;
         end else begin : g_next
            assign dn_vld_w[i] = vld_w[i+1];
            assign dn_key_w[i] = key_w[i+1];
         end

         uks_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .up_valid  (up_vld_w[i]),
            .up_gt     (up_gt_w[i]),
            .up_key    (up_key_w[i]),
            .dn_valid  (dn_vld_w[i]),
            .dn_key    (dn_key_w[i]),
            .valid_out (vld_w[i]),
            .gt_out    (gt_w[i]),
            .key_out   (key_w[i])
         );
      end
   endgenerate

   always_comb begin
      drain_in = drain_ff;
      lost_in  = lost_ff;
      if (req_accept && full) begin
         lost_in = 1'b1;
      end
      if (req_accept && req_data.batch_end) begin
         drain_in = 1'b1;
      end else if (rsp_accept && last_held) begin
         drain_in = 1'b0;
         lost_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
         lost_ff  <= 1'b0;
      end else begin
         drain_ff <= drain_in;
         lost_ff  <= lost_in;
      end
   end

   // occupied cells form a contiguous run from the head
   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      (vld_w[MAX_KEYS-1:1] & ~vld_w[MAX_KEYS-2:0]) == '0)
      else $error("chain occupancy has a hole");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> vld_w[0])
      else $error("draining with an empty chain");

   a_final_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && rsp_data.final_key |=> !vld_w[0] && !drain_ff && !lost_ff)
      else $error("chain not empty after final beat");

   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      req_accept && full |=> lost_ff && vld_w[MAX_KEYS-1])
      else $error("dropped key not flagged");

endmodule

`default_nettype wire
